// ----- rtl/core/lrni_pkg.sv -----
// Shared types, widths and helpers for the lidar range noise injector.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package lrni_pkg;

    // Field widths fixed by the interface.
    localparam int COORD_W    = 24;
    localparam int NOISE_W    = 16;
    localparam int TBL_W      = 23;
    localparam int AMT_W      = 24;
    localparam int MODE_W     = 2;
    localparam int ENT_W      = 6;
    localparam int IDX_W      = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    // Internal arithmetic widths.
    localparam int R_W    = 32;
    localparam int RMAG_W = 40;
    localparam int DIV_W  = 32;
    localparam int E_W    = 31;

    localparam int TABLE_DEPTH_DEF = 32;

    // Error modes; any other code selects the table.
    localparam logic [MODE_W-1:0] MODE_CONST = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PROP  = 2'd1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MODE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AMOUNT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES = 2'd2;

    // Datapath operations issued by the controller.
    typedef enum logic [4:0] {
        DP_NOP,
        DP_ACCEPT,
        DP_SQ,
        DP_SQRT_INIT,
        DP_SQRT_STEP,
        DP_PREP,
        DP_TREAD,
        DP_E_ZERO,
        DP_E_LAST,
        DP_E_HIT,
        DP_TSAVE,
        DP_IPREP,
        DP_IMUL,
        DP_DIVI_INT,
        DP_DIVI_CRD,
        DP_DIV_STEP,
        DP_IFIN,
        DP_DELTA,
        DP_RANGE,
        DP_PLO,
        DP_PHI,
        DP_CFIN,
        DP_ZOUT,
        DP_PUSH
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic [1:0] sel;
    } dp_cmd_t;

    typedef struct packed {
        logic r_zero;
        logic tbl_le;
        logic tbl_eq;
    } dp_stat_t;

    // Saturate a sign and magnitude to a signed 24-bit word.
    function automatic logic [COORD_W-1:0] sat24(input logic neg, input logic [40:0] mag);
        if (!neg) begin
            return (mag > 41'h7FFFFF) ? 24'h7FFFFF : mag[COORD_W-1:0];
        end
        if (mag >= 41'h800000) begin
            return 24'h800000;
        end
        return (~mag[COORD_W-1:0]) + 24'd1;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/lidar_range_noise_injector.sv -----
// Top level of the lidar range noise injector: configuration registers,
// controller and datapath. Depends on lrni_pkg, lrni_ctrl, lrni_dp, lrni_ram.
//
//  Channel  Handshake            Carries
//  s_       s_valid / s_ready    op, point x/y/z, noise sample, table entry
//  m_       m_valid / m_ready    noisy x/y/z
//  cfg_     cfg_valid/cfg_ready  cfg_index, cfg_wdata
//
// A load word leaves the block ready for the next word. A point word runs the
// 32-step bit-pair square root, three 32-step passes of the shared restoring
// divider for scaling, a table read per entry and a divider pass to interpolate.
// A finished word waits in the output register while the next word is taken; a
// second finished word holds the block, and so the input, until the first leaves.
// Synchronous active-low reset clears control and configuration; the table
// holds no reset value and needs no clearing pass.
`default_nettype none

module lidar_range_noise_injector #(
    parameter int TABLE_DEPTH = lrni_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic                                s_op,
    input  wire logic signed [lrni_pkg::COORD_W-1:0] s_point_x,
    input  wire logic signed [lrni_pkg::COORD_W-1:0] s_point_y,
    input  wire logic signed [lrni_pkg::COORD_W-1:0] s_point_z,
    input  wire logic signed [lrni_pkg::NOISE_W-1:0] s_noise_sample,
    input  wire logic        [lrni_pkg::IDX_W-1:0]   s_entry_index,
    input  wire logic        [lrni_pkg::TBL_W-1:0]   s_entry_distance,
    input  wire logic        [lrni_pkg::TBL_W-1:0]   s_entry_error,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic signed      [lrni_pkg::COORD_W-1:0] m_noisy_x,
    output logic signed      [lrni_pkg::COORD_W-1:0] m_noisy_y,
    output logic signed      [lrni_pkg::COORD_W-1:0] m_noisy_z,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic        [lrni_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic        [lrni_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import lrni_pkg::*;

    localparam int ADDR_W = $clog2(TABLE_DEPTH);

    logic [MODE_W-1:0] mode_reg;
    logic [AMT_W-1:0]  amount_reg;
    logic [ENT_W-1:0]  entries_reg;
    dp_cmd_t           cmd;
    dp_stat_t          stat;
    logic [ADDR_W-1:0] tbl_addr;

    assign cfg_ready = 1'b1;

    // Configuration registers; unknown indexes are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= '0;
            amount_reg  <= '0;
            entries_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_MODE:    mode_reg    <= cfg_wdata[MODE_W-1:0];
                CFG_AMOUNT:  amount_reg  <= cfg_wdata[AMT_W-1:0];
                CFG_ENTRIES: entries_reg <= cfg_wdata[ENT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    lrni_ctrl #(
        .TABLE_DEPTH(TABLE_DEPTH),
        .ADDR_W     (ADDR_W)
    ) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_op         (s_op),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .error_mode   (mode_reg),
        .table_entries(entries_reg),
        .stat         (stat),
        .cmd          (cmd),
        .tbl_addr     (tbl_addr)
    );

    lrni_dp #(
        .TABLE_DEPTH(TABLE_DEPTH),
        .ADDR_W     (ADDR_W)
    ) u_dp (
        .aclk            (aclk),
        .cmd             (cmd),
        .stat            (stat),
        .tbl_addr        (tbl_addr),
        .s_op            (s_op),
        .s_point_x       (s_point_x),
        .s_point_y       (s_point_y),
        .s_point_z       (s_point_z),
        .s_noise_sample  (s_noise_sample),
        .s_entry_index   (s_entry_index),
        .s_entry_distance(s_entry_distance),
        .s_entry_error   (s_entry_error),
        .error_mode      (mode_reg),
        .error_amount    (amount_reg),
        .m_noisy_x       (m_noisy_x),
        .m_noisy_y       (m_noisy_y),
        .m_noisy_z       (m_noisy_z)
    );

`ifndef SYNTHESIS
    // A load word leaves the block ready for the next word.
    a_load_no_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_op |=> s_ready)
        else $error("load word stalled the input");

    // A point word occupies the block.
    a_point_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !s_op |=> !s_ready)
        else $error("point word did not start processing");

    // A new result appears only at the end of a point's processing.
    a_result_from_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result word appeared while idle");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/lrni_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Holds the breakpoint table; depends on nothing.
`default_nettype none

module lrni_ram #(
    parameter int WIDTH  = 46,
    parameter int DEPTH  = 32,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/lrni_ctrl.sv -----
// Sequencing state machine of the noise injector: handshakes, loop counters,
// table walk. Depends on lrni_pkg; drives the datapath through dp_cmd_t.
`default_nettype none

module lrni_ctrl #(
    parameter int TABLE_DEPTH = lrni_pkg::TABLE_DEPTH_DEF,
    parameter int ADDR_W      = $clog2(TABLE_DEPTH)
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic                       s_op,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    input  wire logic [lrni_pkg::MODE_W-1:0] error_mode,
    input  wire logic [lrni_pkg::ENT_W-1:0]  table_entries,
    input  wire lrni_pkg::dp_stat_t          stat,
    output lrni_pkg::dp_cmd_t                cmd,
    output logic      [ADDR_W-1:0]           tbl_addr
);
    import lrni_pkg::*;

    localparam int KW = $clog2(TABLE_DEPTH + 1);
    localparam int NW = (KW > ENT_W) ? KW : ENT_W;

    typedef enum logic [4:0] {
        S_IDLE, S_SQ, S_SQRT_INIT, S_SQRT, S_PREP, S_TREAD, S_TCMP, S_IMUL,
        S_DIVI, S_DIV, S_IFIN, S_DELTA, S_RANGE, S_PLO, S_PHI, S_CDIVI,
        S_CFIN, S_ZOUT, S_DONE
    } state_t;

    state_t         state_reg, state_next;
    logic [1:0]     sel_reg, sel_next;
    logic [4:0]     cnt_reg, cnt_next;
    logic [NW-1:0]  k_reg, k_next;
    logic           crd_reg, crd_next;
    logic           m_valid_reg, m_valid_next;
    logic [NW-1:0]  ent_ext;
    logic [NW-1:0]  n_eff;
    logic           push;

    assign ent_ext  = NW'(table_entries);
    assign n_eff    = (ent_ext > NW'(TABLE_DEPTH)) ? NW'(TABLE_DEPTH) : ent_ext;
    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = m_valid_reg;
    assign tbl_addr = k_reg[ADDR_W-1:0];
    assign push     = (state_reg == S_DONE) && (!m_valid_reg || m_ready);

    // Next state and command decode.
    always_comb begin
        state_next = state_reg;
        sel_next   = sel_reg;
        cnt_next   = cnt_reg;
        k_next     = k_reg;
        crd_next   = crd_reg;
        cmd.op     = DP_NOP;
        cmd.sel    = sel_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.op = DP_ACCEPT;
                    if (!s_op) begin
                        sel_next   = 2'd0;
                        state_next = S_SQ;
                    end
                end
            end
            S_SQ: begin
                cmd.op = DP_SQ;
                if (sel_reg == 2'd2) begin
                    state_next = S_SQRT_INIT;
                end else begin
                    sel_next = sel_reg + 2'd1;
                end
            end
            S_SQRT_INIT: begin
                cmd.op     = DP_SQRT_INIT;
                cnt_next   = 5'd0;
                state_next = S_SQRT;
            end
            S_SQRT: begin
                cmd.op   = DP_SQRT_STEP;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd31) begin
                    state_next = S_PREP;
                end
            end
            S_PREP: begin
                cmd.op = DP_PREP;
                k_next = '0;
                if (error_mode == MODE_CONST || error_mode == MODE_PROP || stat.r_zero) begin
                    state_next = S_DELTA;
                end else begin
                    state_next = S_TREAD;
                end
            end
            S_TREAD: begin
                if (k_reg == n_eff) begin
                    cmd.op     = (n_eff == '0) ? DP_E_ZERO : DP_E_LAST;
                    state_next = S_DELTA;
                end else begin
                    cmd.op     = DP_TREAD;
                    state_next = S_TCMP;
                end
            end
            S_TCMP: begin
                if (stat.tbl_le && stat.tbl_eq) begin
                    cmd.op     = DP_E_HIT;
                    state_next = S_DELTA;
                end else if (stat.tbl_le) begin
                    cmd.op     = DP_TSAVE;
                    k_next     = k_reg + 1'b1;
                    state_next = S_TREAD;
                end else if (k_reg == '0) begin
                    cmd.op     = DP_E_ZERO;
                    state_next = S_DELTA;
                end else begin
                    cmd.op     = DP_IPREP;
                    state_next = S_IMUL;
                end
            end
            S_IMUL: begin
                cmd.op     = DP_IMUL;
                state_next = S_DIVI;
            end
            S_DIVI: begin
                cmd.op     = DP_DIVI_INT;
                crd_next   = 1'b0;
                cnt_next   = 5'd0;
                state_next = S_DIV;
            end
            S_DIV: begin
                cmd.op   = DP_DIV_STEP;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd31) begin
                    state_next = crd_reg ? S_CFIN : S_IFIN;
                end
            end
            S_IFIN: begin
                cmd.op     = DP_IFIN;
                state_next = S_DELTA;
            end
            S_DELTA: begin
                cmd.op     = DP_DELTA;
                state_next = S_RANGE;
            end
            S_RANGE: begin
                cmd.op     = DP_RANGE;
                sel_next   = 2'd0;
                state_next = stat.r_zero ? S_ZOUT : S_PLO;
            end
            S_PLO: begin
                cmd.op     = DP_PLO;
                state_next = S_PHI;
            end
            S_PHI: begin
                cmd.op     = DP_PHI;
                state_next = S_CDIVI;
            end
            S_CDIVI: begin
                cmd.op     = DP_DIVI_CRD;
                crd_next   = 1'b1;
                cnt_next   = 5'd0;
                state_next = S_DIV;
            end
            S_CFIN: begin
                cmd.op = DP_CFIN;
                if (sel_reg == 2'd2) begin
                    state_next = S_DONE;
                end else begin
                    sel_next   = sel_reg + 2'd1;
                    state_next = S_PLO;
                end
            end
            S_ZOUT: begin
                cmd.op     = DP_ZOUT;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (push) begin
                    cmd.op     = DP_PUSH;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Result word valid: set on push, cleared when taken.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (push) begin
            m_valid_next = 1'b1;
        end
    end

    // State and registered outputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            sel_reg     <= 2'd0;
            cnt_reg     <= 5'd0;
            k_reg       <= '0;
            crd_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            sel_reg     <= sel_next;
            cnt_reg     <= cnt_next;
            k_reg       <= k_next;
            crd_reg     <= crd_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/lrni_dp.sv -----
// Datapath of the noise injector: range square root, error term, table
// interpolation, shared divider and output scaling. Depends on lrni_pkg, lrni_ram.
`default_nettype none

module lrni_dp #(
    parameter int TABLE_DEPTH = lrni_pkg::TABLE_DEPTH_DEF,
    parameter int ADDR_W      = $clog2(TABLE_DEPTH)
) (
    input  wire logic                               aclk,
    input  wire lrni_pkg::dp_cmd_t                  cmd,
    output lrni_pkg::dp_stat_t                      stat,
    input  wire logic              [ADDR_W-1:0]     tbl_addr,
    input  wire logic                               s_op,
    input  wire logic signed [lrni_pkg::COORD_W-1:0] s_point_x,
    input  wire logic signed [lrni_pkg::COORD_W-1:0] s_point_y,
    input  wire logic signed [lrni_pkg::COORD_W-1:0] s_point_z,
    input  wire logic signed [lrni_pkg::NOISE_W-1:0] s_noise_sample,
    input  wire logic        [lrni_pkg::IDX_W-1:0]   s_entry_index,
    input  wire logic        [lrni_pkg::TBL_W-1:0]   s_entry_distance,
    input  wire logic        [lrni_pkg::TBL_W-1:0]   s_entry_error,
    input  wire logic        [lrni_pkg::MODE_W-1:0]  error_mode,
    input  wire logic        [lrni_pkg::AMT_W-1:0]   error_amount,
    output logic signed      [lrni_pkg::COORD_W-1:0] m_noisy_x,
    output logic signed      [lrni_pkg::COORD_W-1:0] m_noisy_y,
    output logic signed      [lrni_pkg::COORD_W-1:0] m_noisy_z
);
    import lrni_pkg::*;

    localparam int RAM_W = 2 * TBL_W;
    localparam int IW    = (IDX_W > ADDR_W + 1) ? IDX_W : ADDR_W + 1;

    // Captured point.
    logic [COORD_W-1:0] cm_reg [3];
    logic               cneg_reg [3];
    logic [NOISE_W-1:0] nmag_reg;
    logic               nneg_reg;

    // Range and error terms.
    logic [47:0]        s_reg;
    logic [63:0]        sv_reg, sres_reg, sbit_reg;
    logic [AMT_W-1:0]   p_reg;
    logic [E_W-1:0]     e_reg;
    logic [RMAG_W-1:0]  delta_reg, rmag_reg;
    logic               rneg_reg;

    // Table walk and interpolation.
    logic [TBL_W-1:0]   prev_dist_reg, prev_err_reg;
    logic [TBL_W-1:0]   ediff_reg;
    logic               eneg_reg;
    logic [R_W-1:0]     num_reg, den_reg;
    logic [63:0]        prod_reg;

    // Shared divider and output scaling.
    logic [DIV_W-1:0]   dv_rem_reg, dv_lo_reg, dv_den_reg;
    logic [63:0]        pp_reg;
    logic [COORD_W-1:0] res_reg [3];
    logic [COORD_W-1:0] mx_reg, my_reg, mz_reg;

    // Combinational helpers.
    logic [R_W-1:0]     r16;
    logic [RAM_W-1:0]   rd_data;
    logic [TBL_W-1:0]   rd_dist, rd_err;
    logic [COORD_W-1:0] cm_sel;
    logic               cneg_sel;
    logic [63:0]        sq_t;
    logic [DIV_W:0]     dv_t;
    logic               dv_ge;
    logic [40:0]        rsum;
    logic               tbl_we;
    logic [COORD_W-1:0] sat_val;
    logic               crd_ovf;

    assign r16     = sres_reg[R_W-1:0];
    assign rd_dist = rd_data[RAM_W-1:TBL_W];
    assign rd_err  = rd_data[TBL_W-1:0];
    assign sq_t    = sres_reg + sbit_reg;
    assign dv_t    = {dv_rem_reg, dv_lo_reg[DIV_W-1]};
    assign dv_ge   = dv_t >= {1'b0, dv_den_reg};
    assign tbl_we  = (cmd.op == DP_ACCEPT) && s_op &&
                     (IW'(s_entry_index) < IW'(TABLE_DEPTH));
    assign crd_ovf = pp_reg >= {8'd0, r16, 24'd0};
    assign sat_val = sat24(cneg_sel ^ rneg_reg, crd_ovf ? 41'h1000000 : 41'(dv_lo_reg));

    assign stat.r_zero = (r16 == '0);
    assign stat.tbl_le = {1'b0, rd_dist, 8'd0} <= r16;
    assign stat.tbl_eq = {1'b0, rd_dist, 8'd0} == r16;

    assign m_noisy_x = mx_reg;
    assign m_noisy_y = my_reg;
    assign m_noisy_z = mz_reg;

    // Coordinate selected for the current step.
    always_comb begin
        unique case (cmd.sel)
            2'd0: begin
                cm_sel   = cm_reg[0];
                cneg_sel = cneg_reg[0];
            end
            2'd1: begin
                cm_sel   = cm_reg[1];
                cneg_sel = cneg_reg[1];
            end
            default: begin
                cm_sel   = cm_reg[2];
                cneg_sel = cneg_reg[2];
            end
        endcase
    end

    // Magnitude of the perturbed range, saturated further down.
    always_comb begin
        if (!nneg_reg) begin
            rsum = 41'(r16) + 41'(delta_reg);
        end else if (delta_reg <= RMAG_W'(r16)) begin
            rsum = 41'(r16) - 41'(delta_reg);
        end else begin
            rsum = 41'(delta_reg) - 41'(r16);
        end
    end

    // Breakpoint table: distance in the upper half, error in the lower half.
    lrni_ram #(
        .WIDTH (RAM_W),
        .DEPTH (TABLE_DEPTH),
        .ADDR_W(ADDR_W)
    ) u_tbl (
        .aclk (aclk),
        .we   (tbl_we),
        .waddr(ADDR_W'(s_entry_index)),
        .wdata({s_entry_distance, s_entry_error}),
        .re   (cmd.op == DP_TREAD),
        .raddr(tbl_addr),
        .rdata(rd_data)
    );

    // Datapath registers, one operation per cycle.
    always_ff @(posedge aclk) begin
        unique case (cmd.op)
            DP_ACCEPT: begin
                cneg_reg[0] <= s_point_x[COORD_W-1];
                cneg_reg[1] <= s_point_y[COORD_W-1];
                cneg_reg[2] <= s_point_z[COORD_W-1];
                cm_reg[0]   <= s_point_x[COORD_W-1] ? (~$unsigned(s_point_x) + 24'd1)
                                                    : $unsigned(s_point_x);
                cm_reg[1]   <= s_point_y[COORD_W-1] ? (~$unsigned(s_point_y) + 24'd1)
                                                    : $unsigned(s_point_y);
                cm_reg[2]   <= s_point_z[COORD_W-1] ? (~$unsigned(s_point_z) + 24'd1)
                                                    : $unsigned(s_point_z);
                nneg_reg    <= s_noise_sample[NOISE_W-1];
                nmag_reg    <= s_noise_sample[NOISE_W-1] ? (~$unsigned(s_noise_sample) + 16'd1)
                                                         : $unsigned(s_noise_sample);
                s_reg       <= '0;
                e_reg       <= '0;
            end
            DP_SQ: begin
                s_reg <= s_reg + 48'(cm_sel * cm_sel);
            end
            DP_SQRT_INIT: begin
                sv_reg   <= {s_reg, 16'd0};
                sres_reg <= '0;
                sbit_reg <= 64'd1 << 62;
            end
            DP_SQRT_STEP: begin
                if (sv_reg >= sq_t) begin
                    sv_reg   <= sv_reg - sq_t;
                    sres_reg <= (sres_reg >> 1) + sbit_reg;
                end else begin
                    sres_reg <= sres_reg >> 1;
                end
                sbit_reg <= sbit_reg >> 2;
            end
            DP_PREP: begin
                p_reg <= AMT_W'((40'(nmag_reg) * 40'(error_amount)) >> 15);
            end
            DP_E_ZERO: begin
                e_reg <= '0;
            end
            DP_E_LAST: begin
                e_reg <= {prev_err_reg, 8'd0};
            end
            DP_E_HIT: begin
                e_reg <= {rd_err, 8'd0};
            end
            DP_TSAVE: begin
                prev_dist_reg <= rd_dist;
                prev_err_reg  <= rd_err;
            end
            DP_IPREP: begin
                eneg_reg  <= rd_err < prev_err_reg;
                ediff_reg <= (rd_err < prev_err_reg) ? (prev_err_reg - rd_err)
                                                     : (rd_err - prev_err_reg);
                num_reg   <= r16 - {1'b0, prev_dist_reg, 8'd0};
                den_reg   <= {1'b0, rd_dist, 8'd0} - {1'b0, prev_dist_reg, 8'd0};
            end
            DP_IMUL: begin
                prod_reg <= 64'({ediff_reg, 8'd0}) * 64'(num_reg);
            end
            DP_DIVI_INT: begin
                dv_rem_reg <= prod_reg[63:32];
                dv_lo_reg  <= prod_reg[31:0];
                dv_den_reg <= den_reg;
            end
            DP_DIVI_CRD: begin
                dv_rem_reg <= pp_reg[63:32];
                dv_lo_reg  <= pp_reg[31:0];
                dv_den_reg <= r16;
            end
            DP_DIV_STEP: begin
                dv_rem_reg <= dv_ge ? DIV_W'(dv_t - {1'b0, dv_den_reg}) : dv_t[DIV_W-1:0];
                dv_lo_reg  <= {dv_lo_reg[DIV_W-2:0], dv_ge};
            end
            DP_IFIN: begin
                e_reg <= eneg_reg ? E_W'({prev_err_reg, 8'd0} - dv_lo_reg)
                                  : E_W'({prev_err_reg, 8'd0} + dv_lo_reg);
            end
            DP_DELTA: begin
                if (error_mode == MODE_CONST) begin
                    delta_reg <= RMAG_W'(p_reg);
                end else if (error_mode == MODE_PROP) begin
                    delta_reg <= RMAG_W'((56'(p_reg) * 56'(r16)) >> 16);
                end else begin
                    delta_reg <= RMAG_W'((47'(nmag_reg) * 47'(e_reg)) >> 15);
                end
            end
            DP_RANGE: begin
                rneg_reg <= nneg_reg && (delta_reg > RMAG_W'(r16));
                rmag_reg <= rsum[40] ? {RMAG_W{1'b1}} : rsum[RMAG_W-1:0];
            end
            DP_PLO: begin
                pp_reg <= 64'(44'(cm_sel) * 44'(rmag_reg[19:0]));
            end
            DP_PHI: begin
                pp_reg <= pp_reg + ({20'd0, 44'(cm_sel) * 44'(rmag_reg[39:20])} << 20);
            end
            DP_CFIN: begin
                unique case (cmd.sel)
                    2'd0:    res_reg[0] <= sat_val;
                    2'd1:    res_reg[1] <= sat_val;
                    default: res_reg[2] <= sat_val;
                endcase
            end
            DP_ZOUT: begin
                res_reg[0] <= sat24(rneg_reg, 41'(rmag_reg >> 8));
                res_reg[1] <= '0;
                res_reg[2] <= '0;
            end
            DP_PUSH: begin
                mx_reg <= res_reg[0];
                my_reg <= res_reg[1];
                mz_reg <= res_reg[2];
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- verif/lidar_range_noise_injector_test.sv -----
// Self-checking testbench for the lidar range noise injector: drives point and
// table load words, writes the configuration registers and checks every result.
// Depends on lrni_pkg and the lidar_range_noise_injector top level.
`default_nettype none

module lidar_range_noise_injector_test;
    import lrni_pkg::*;

    localparam logic OP_POINT = 1'b0;
    localparam logic OP_LOAD  = 1'b1;
    localparam logic [MODE_W-1:0] MODE_TABLE = 2'd2;
    localparam logic [MODE_W-1:0] MODE_ALIAS = 2'd3;
    localparam int NSLOTS     = 32;
    localparam int DRAIN_WAIT = 400;
    localparam int HOLD_LEN   = 300;
    localparam int WDOG_LIMIT = 20000;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
    } noisy_point_t;

    // Predicts the perturbed points and holds the ones still owed by the block.
    class noisy_point_board;
        noisy_point_t       owed[$];
        logic [MODE_W-1:0]  mode;
        logic [AMT_W-1:0]   amount;
        logic [ENT_W-1:0]   entries;
        logic [TBL_W-1:0]   brk_dist[NSLOTS];
        logic [TBL_W-1:0]   err[NSLOTS];
        int                 errors;

        function new();
            mode = MODE_CONST;
            amount = '0;
            entries = '0;
            errors = 0;
            foreach (brk_dist[i]) begin
                brk_dist[i] = '0;
                err[i] = '0;
            end
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_MODE) mode = data[MODE_W-1:0];
            else if (idx == CFG_AMOUNT) amount = data[AMT_W-1:0];
            else if (idx == CFG_ENTRIES) entries = data[ENT_W-1:0];
        endfunction

        function logic [63:0] root(logic [63:0] v);
            logic [63:0] res, b;
            res = 0;
            b = 64'd1 << 62;
            while (b > v) b >>= 2;
            while (b != 0) begin
                if (v >= res + b) begin
                    v -= res + b;
                    res = (res >> 1) + b;
                end else begin
                    res >>= 1;
                end
                b >>= 2;
            end
            return res;
        endfunction

        function logic [COORD_W-1:0] clamp(logic neg, logic [63:0] mag);
            if (!neg) return (mag > 64'h7FFFFF) ? 24'h7FFFFF : mag[COORD_W-1:0];
            if (mag >= 64'h800000) return 24'h800000;
            return ~mag[COORD_W-1:0] + 24'd1;
        endfunction

        // Interpolated table error for a range with 8 fractional bits.
        function logic [63:0] lookup_error(logic [63:0] r);
            logic [63:0] n, k, d0, d1, e0, e1;
            n = (entries > NSLOTS) ? NSLOTS : entries;
            k = 0;
            while (k < n && ({41'd0, brk_dist[k]} << 8) <= r) begin
                if (({41'd0, brk_dist[k]} << 8) == r) return {41'd0, err[k]} << 8;
                k++;
            end
            if (n == 0) return 0;
            if (k == n) return {41'd0, err[n-1]} << 8;
            if (k == 0) return 0;
            d0 = {41'd0, brk_dist[k-1]} << 8;
            d1 = {41'd0, brk_dist[k]} << 8;
            e0 = {41'd0, err[k-1]};
            e1 = {41'd0, err[k]};
            if (e1 >= e0) return (e0 << 8) + (((e1 - e0) << 8) * (r - d0)) / (d1 - d0);
            return (e0 << 8) - (((e0 - e1) << 8) * (r - d0)) / (d1 - d0);
        endfunction

        function void note_word(logic op, logic signed [COORD_W-1:0] c[3],
                                logic signed [NOISE_W-1:0] noise, logic [IDX_W-1:0] idx,
                                logic [TBL_W-1:0] d, logic [TBL_W-1:0] e);
            logic [63:0] cm[3], s, r, nmag, delta, rmag;
            logic nneg, rneg;
            noisy_point_t p;
            if (op == OP_LOAD) begin
                brk_dist[idx] = d;
                err[idx] = e;
                return;
            end
            s = 0;
            for (int i = 0; i < 3; i++) begin
                cm[i] = c[i] < 0 ? 64'(-64'(c[i])) : 64'(c[i]);
                s += cm[i] * cm[i];
            end
            r = root(s << 16);
            nneg = noise < 0;
            nmag = nneg ? 64'(-64'(noise)) : 64'(noise);
            if (mode == MODE_CONST) delta = (nmag * amount) >> 15;
            else if (mode == MODE_PROP) delta = (((nmag * amount) >> 15) * r) >> 16;
            else delta = (r == 0) ? 0 : (nmag * lookup_error(r)) >> 15;
            if (!nneg) begin
                rneg = 0;
                rmag = r + delta;
            end else if (delta <= r) begin
                rneg = 0;
                rmag = r - delta;
            end else begin
                rneg = 1;
                rmag = delta - r;
            end
            if (rmag > 64'hFF_FFFF_FFFF) rmag = 64'hFF_FFFF_FFFF;
            if (r == 0) begin
                p.x = clamp(rneg, rmag >> 8);
                p.y = '0;
                p.z = '0;
            end else begin
                p.x = clamp((c[0] < 0) != rneg, (cm[0] * rmag) / r);
                p.y = clamp((c[1] < 0) != rneg, (cm[1] * rmag) / r);
                p.z = clamp((c[2] < 0) != rneg, (cm[2] * rmag) / r);
            end
            owed = {owed, p};
        endfunction

        function void check_point(noisy_point_t got);
            noisy_point_t want;
            if (owed.size() == 0) begin
                errors++;
                $display("%0t: unexpected result %h %h %h", $time, got.x, got.y, got.z);
                return;
            end
            want = owed.pop_front();
            if (got.x !== want.x) begin
                errors++;
                $display("%0t: noisy_x expected %h actual %h", $time, want.x, got.x);
            end
            if (got.y !== want.y) begin
                errors++;
                $display("%0t: noisy_y expected %h actual %h", $time, want.y, got.y);
            end
            if (got.z !== want.z) begin
                errors++;
                $display("%0t: noisy_z expected %h actual %h", $time, want.z, got.z);
            end
        endfunction
    endclass

    logic                       aclk;
    logic                       aresetn;
    logic                       s_valid, s_ready, s_op;
    logic signed [COORD_W-1:0]  s_point_x, s_point_y, s_point_z;
    logic signed [NOISE_W-1:0]  s_noise_sample;
    logic [IDX_W-1:0]           s_entry_index;
    logic [TBL_W-1:0]           s_entry_distance, s_entry_error;
    logic                       m_valid, m_ready;
    logic signed [COORD_W-1:0]  m_noisy_x, m_noisy_y, m_noisy_z;
    logic                       cfg_valid, cfg_ready;
    logic [CFG_IDX_W-1:0]       cfg_index;
    logic [CFG_DATA_W-1:0]      cfg_wdata;

    noisy_point_board board;
    bit                 no_idle;
    bit                 hold_req;
    int                 idle_count;

    lidar_range_noise_injector i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_op(s_op),
        .s_point_x(s_point_x), .s_point_y(s_point_y), .s_point_z(s_point_z),
        .s_noise_sample(s_noise_sample), .s_entry_index(s_entry_index),
        .s_entry_distance(s_entry_distance), .s_entry_error(s_entry_error),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_noisy_x(m_noisy_x), .m_noisy_y(m_noisy_y), .m_noisy_z(m_noisy_z),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    // Sends one input word after a random gap and records it once accepted.
    task automatic send_word(logic op, logic signed [COORD_W-1:0] x,
                             logic signed [COORD_W-1:0] y, logic signed [COORD_W-1:0] z,
                             logic signed [NOISE_W-1:0] n, logic [IDX_W-1:0] idx,
                             logic [TBL_W-1:0] d, logic [TBL_W-1:0] e);
        int gap;
        logic signed [COORD_W-1:0] c[3];
        gap = no_idle ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_op <= op;
        s_point_x <= x;
        s_point_y <= y;
        s_point_z <= z;
        s_noise_sample <= n;
        s_entry_index <= idx;
        s_entry_distance <= d;
        s_entry_error <= e;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        c[0] = x;
        c[1] = y;
        c[2] = z;
        board.note_word(op, c, n, idx, d, e);
    endtask

    task automatic send_point(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y,
                              logic signed [COORD_W-1:0] z, logic signed [NOISE_W-1:0] n);
        send_word(OP_POINT, x, y, z, n, IDX_W'($urandom), TBL_W'($urandom), TBL_W'($urandom));
    endtask

    task automatic send_load(logic [IDX_W-1:0] idx, logic [TBL_W-1:0] d, logic [TBL_W-1:0] e);
        send_word(OP_LOAD, COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
                  NOISE_W'($urandom), idx, d, e);
    endtask

    // Waits until every owed result has come, then lets a last word finish.
    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (board.owed.size() != 0);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_index <= idx;
        cfg_wdata <= data;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        board.set_reg(idx, data);
    endtask

    // Fills every slot with ascending breakpoints of a random spacing.
    task automatic load_table();
        int step, base;
        step = $urandom_range(1, 1 << $urandom_range(2, 18));
        base = $urandom_range(0, step);
        for (int i = 0; i < NSLOTS; i++)
            send_load(IDX_W'(i), TBL_W'(base + i * step),
                      TBL_W'($urandom >> $urandom_range(9, 31)));
    endtask

    function automatic logic signed [COORD_W-1:0] rand_coord();
        return COORD_W'($signed(COORD_W'($urandom)) >>> $urandom_range(0, 23));
    endfunction

    function automatic logic signed [NOISE_W-1:0] rand_noise();
        case ($urandom_range(0, 9))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return '0;
            default: return NOISE_W'($urandom);
        endcase
    endfunction

    // Random word: mostly general points, some placed on or next to a breakpoint, and occasionally a table load.
    task automatic send_random();
        int k;
        logic signed [COORD_W-1:0] d;
        if ($urandom_range(0, 19) == 0) begin
            send_load(IDX_W'($urandom), TBL_W'($urandom), TBL_W'($urandom));
        end else if ($urandom_range(0, 4) == 0) begin
            k = $urandom_range(0, NSLOTS - 1);
            d = COORD_W'({1'b0, board.brk_dist[k]}) + COORD_W'($urandom_range(0, 2)) - 24'sd1;
            if ($urandom_range(0, 1)) d = -d;
            send_point(d, '0, '0, rand_noise());
        end else begin
            send_point(rand_coord(), rand_coord(), rand_coord(), rand_noise());
        end
    endtask

    // Result side: random stalls, and one long hold-off on request.
    initial begin
        int gap;
        bit held;
        noisy_point_t got;
        held = 0;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            if (hold_req && !held) begin
                held = 1;
                m_ready <= 1'b0;
                repeat (HOLD_LEN) @(posedge aclk);
            end
            gap = no_idle ? 0 : $urandom_range(0, 11);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            got.x = m_noisy_x;
            got.y = m_noisy_y;
            got.z = m_noisy_z;
            board.check_point(got);
        end
    end

    // Watchdog on cycles without any accepted word.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)
            || !aresetn) begin
            idle_count <= 0;
        end else begin
            idle_count <= idle_count + 1;
        end
        if (idle_count > WDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Main sequence: setup, directed special cases, then random phases.
    initial begin
        logic [MODE_W-1:0]     modes[9];
        logic [CFG_DATA_W-1:0] amounts[9];
        logic [ENT_W-1:0]      counts[9];
        board = new();
        no_idle = 0;
        hold_req = 0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_op = OP_POINT;
        s_point_x = '0;
        s_point_y = '0;
        s_point_z = '0;
        s_noise_sample = '0;
        s_entry_index = '0;
        s_entry_distance = '0;
        s_entry_error = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_MODE;
        cfg_wdata = '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        modes   = '{MODE_CONST, MODE_CONST, MODE_PROP, MODE_PROP, MODE_TABLE,
                    MODE_TABLE, MODE_ALIAS, MODE_TABLE, MODE_TABLE};
        amounts = '{24'hFFFFFF, 24'h0, 24'hFFFFFF, 24'h004000, 24'h123456,
                    24'h0, 24'h010000, 24'hFFFFFF, 24'h0};
        counts  = '{6'd32, 6'd0, 6'd1, 6'd63, 6'd32, 6'd0, 6'd5, 6'd63, 6'd1};

        // Every slot is written before any table read can happen.
        load_table();
        for (int ph = 0; ph < 9; ph++) begin
            drain();
            write_reg(CFG_MODE, CFG_DATA_W'(modes[ph]));
            write_reg(CFG_AMOUNT, amounts[ph]);
            write_reg(CFG_ENTRIES, CFG_DATA_W'(counts[ph]));
            no_idle = (ph % 3 == 1);
            if (ph == 3) hold_req = 1;
            if (ph == 4) load_table();
            // Zero range, saturating extremes and a breakpoint hit or overrun.
            send_point('0, '0, '0, 16'sh7FFF);
            send_point('0, '0, '0, 16'sh8000);
            send_point(24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 16'sh7FFF);
            send_point(24'sh800000, 24'sh800000, 24'sh800000, 16'sh8000);
            send_point(24'sh7FFFFF, '0, '0, 16'sh8000);
            send_point(COORD_W'({1'b0, board.brk_dist[0]}), '0, '0, 16'sh7FFF);
            for (int i = 0; i < 95; i++) send_random();
        end
        drain();
        if (board.errors == 0 && board.owed.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
